>>> hw/rtl/tgc_pkg.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier package
// Shared constants, codes and types for the gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int PATH_BITS      = 24;
  localparam int TIME_BITS      = 32;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int GEST_BITS      = 3;

  localparam logic [15:0] TAP_MAX_MIN    = 16'd80;
  localparam logic [15:0] DBL_WINDOW_MIN = 16'd120;
  localparam logic [15:0] HOLD_MIN_MIN   = 16'd400;
  localparam logic [9:0]  STILL_MIN      = 10'd4;
  localparam logic [9:0]  STROKE_MARGIN  = 10'd8;

  typedef enum logic [GEST_BITS-1:0] {
    G_NONE   = 3'd0,
    G_TAP    = 3'd1,
    G_DOUBLE = 3'd2,
    G_HOLD   = 3'd3,
    G_STROKE = 3'd4
  } gesture_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    R_TAP_MAX    = 3'd0,
    R_DBL_WINDOW = 3'd1,
    R_HOLD_MIN   = 3'd2,
    R_STILL      = 3'd3,
    R_STROKE     = 3'd4,
    R_REACH      = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SQX, S_SQY, S_ROOT, S_POST, S_OUT
  } state_t;

  // What the current square root is for.
  typedef enum logic [1:0] {
    J_STEP, J_DISP_DOWN, J_DISP_UP, J_TAP_DIST
  } job_t;

endpackage

>>> hw/rtl/tgc_if.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier channels
// Sample input channel and gesture output channel with valid/ready.
// ----------------------------------------------------------------------------
interface tgc_in_if #(parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF);
  logic                            valid;
  logic                            ready;
  logic                            touch_down;
  logic [COORD_BITS-1:0]           pos_x;
  logic [COORD_BITS-1:0]           pos_y;
  logic [tgc_pkg::TIME_BITS-1:0]   time_ms;
  modport source (output valid, touch_down, pos_x, pos_y, time_ms, input ready);
  modport sink   (input valid, touch_down, pos_x, pos_y, time_ms, output ready);
endinterface

interface tgc_out_if;
  logic                            valid;
  logic                            ready;
  logic [tgc_pkg::GEST_BITS-1:0]   gesture;
  modport source (output valid, gesture, input ready);
  modport sink   (input valid, gesture, output ready);
endinterface

>>> hw/rtl/touch_gesture_classifier_unit.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier
// Classifies touch samples into tap, double tap, hold and stroke gestures.
// ----------------------------------------------------------------------------
// Each sample passes through the accept (idle), decide and result states; a sample
// that needs a distance also runs the shared squarer and the bit-serial square
// root, at most two distances per sample.
// One item at a time: the input is ready only when the block idles.
// Reset (synchronous, rst high) clears the press, hold, tap and path state and
// restores the register defaults.
module touch_gesture_classifier_unit #(
  parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tgc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  tgc_in_if.sink                               in_ch,
  tgc_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [tgc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [tgc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int ROOT_BITS = COORD_BITS + FRAC_BITS + 1;
  localparam int VAL_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 3;
  localparam int SQ_BITS   = 2 * COORD_BITS + 1;
  localparam int CNT_BITS  = $clog2(ROOT_BITS + 1);
  localparam int TB        = tgc_pkg::TIME_BITS;
  localparam int PB        = tgc_pkg::PATH_BITS;

  // Configuration registers
  logic [15:0] tap_max_time, double_tap_window, hold_min_time;
  logic [9:0]  still_radius, stroke_min_distance, double_tap_reach;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_max_time        <= 16'd250;
      double_tap_window   <= 16'd300;
      hold_min_time       <= 16'd600;
      still_radius        <= 10'd10;
      stroke_min_distance <= 10'd24;
      double_tap_reach    <= 10'd24;
    end else if (cfg_we) begin
      case (cfg_index)
        tgc_pkg::R_TAP_MAX:
          tap_max_time <= (cfg_data < tgc_pkg::TAP_MAX_MIN) ?
                          tgc_pkg::TAP_MAX_MIN : cfg_data;
        tgc_pkg::R_DBL_WINDOW:
          double_tap_window <= (cfg_data < tgc_pkg::DBL_WINDOW_MIN) ?
                               tgc_pkg::DBL_WINDOW_MIN : cfg_data;
        tgc_pkg::R_HOLD_MIN:
          hold_min_time <= (cfg_data < tgc_pkg::HOLD_MIN_MIN) ?
                           tgc_pkg::HOLD_MIN_MIN : cfg_data;
        tgc_pkg::R_STILL:
          still_radius <= (cfg_data[9:0] < tgc_pkg::STILL_MIN) ?
                          tgc_pkg::STILL_MIN : cfg_data[9:0];
        tgc_pkg::R_STROKE: stroke_min_distance <= cfg_data[9:0];
        tgc_pkg::R_REACH:  double_tap_reach    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Effective thresholds in fixed point
  logic [10:0] still_p8, stroke_eff;
  logic [9:0]  reach_eff;
  logic [63:0] still_q, stroke_q, reach_q, hold_path_lim;
  assign still_p8      = {1'b0, still_radius} + {1'b0, tgc_pkg::STROKE_MARGIN};
  assign stroke_eff    = ({1'b0, stroke_min_distance} > still_p8) ?
                         {1'b0, stroke_min_distance} : still_p8;
  assign reach_eff     = (double_tap_reach > still_radius) ? double_tap_reach : still_radius;
  assign still_q       = 64'(still_radius) << FRAC_BITS;
  assign stroke_q      = 64'(stroke_eff) << FRAC_BITS;
  assign reach_q       = 64'(reach_eff) << FRAC_BITS;
  assign hold_path_lim = still_q * 64'd9;

  // Sample and gesture state
  tgc_pkg::state_t state, state_next;
  tgc_pkg::job_t   job;
  logic                  s_down;
  logic [COORD_BITS-1:0] s_x, s_y;
  logic [TB-1:0]         s_t;
  logic                  is_pressed, hold_sent, tap_pending;
  logic [TB-1:0]         press_start_time, tap_time;
  logic [COORD_BITS-1:0] start_x, start_y, last_x, last_y, tap_x, tap_y;
  logic [PB-1:0]         path_length_q4;
  logic [tgc_pkg::GEST_BITS-1:0] gesture;

  // Shared distance unit operands and working registers
  logic [COORD_BITS-1:0] opa_x, opa_y, opb_x, opb_y;
  logic [SQ_BITS-1:0]    sq_acc;
  logic [VAL_BITS-1:0]   val;
  logic [REM_BITS-1:0]   rem;
  logic [ROOT_BITS-1:0]  root;
  logic [CNT_BITS-1:0]   cnt;

  logic [COORD_BITS-1:0]   dx, dy, sq_in;
  logic [2*COORD_BITS-1:0] sq_prod;
  logic [SQ_BITS-1:0]      sq_sum;
  logic [REM_BITS-1:0]     rem_sh, trial;
  assign dx      = (opa_x > opb_x) ? opa_x - opb_x : opb_x - opa_x;
  assign dy      = (opa_y > opb_y) ? opa_y - opb_y : opb_y - opa_y;
  assign sq_in   = (state == tgc_pkg::S_SQX) ? dx : dy;
  assign sq_prod = sq_in * sq_in;
  assign sq_sum  = sq_acc + SQ_BITS'(sq_prod);
  assign rem_sh  = {rem[REM_BITS-3:0], val[VAL_BITS-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};

  // Decision terms
  logic [TB-1:0] late_gap, dur;
  logic          late_tap;
  logic [63:0]   root_w, path_w, path_sum;
  assign late_gap = s_t - tap_time;
  assign late_tap = tap_pending && !s_down && (late_gap > TB'(double_tap_window));
  assign dur      = s_t - press_start_time;
  assign root_w   = 64'(root);
  assign path_w   = 64'(path_length_q4);
  assign path_sum = path_w + root_w;

  always_ff @(posedge clk) begin
    if (rst) state <= tgc_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      tgc_pkg::S_IDLE:   if (in_ch.valid) state_next = tgc_pkg::S_DECIDE;
      tgc_pkg::S_DECIDE: begin
        if (late_tap || !is_pressed || (s_down && !is_pressed)) state_next = tgc_pkg::S_OUT;
        else if (!s_down && hold_sent) state_next = tgc_pkg::S_OUT;
        else state_next = tgc_pkg::S_SQX;
      end
      tgc_pkg::S_SQX:    state_next = tgc_pkg::S_SQY;
      tgc_pkg::S_SQY:    state_next = tgc_pkg::S_ROOT;
      tgc_pkg::S_ROOT:   if (cnt == CNT_BITS'(1)) state_next = tgc_pkg::S_POST;
      tgc_pkg::S_POST: begin
        case (job)
          tgc_pkg::J_STEP: state_next = tgc_pkg::S_SQX;
          tgc_pkg::J_DISP_UP: begin
            if (path_w < stroke_q && root_w < stroke_q && dur <= TB'(tap_max_time) &&
                root_w <= still_q && tap_pending)
              state_next = tgc_pkg::S_SQX;
            else
              state_next = tgc_pkg::S_OUT;
          end
          default: state_next = tgc_pkg::S_OUT;
        endcase
      end
      tgc_pkg::S_OUT:    if (out_ch.ready) state_next = tgc_pkg::S_IDLE;
      default:           state_next = tgc_pkg::S_IDLE;
    endcase
  end

  assign in_ch.ready    = (state == tgc_pkg::S_IDLE);
  assign out_ch.valid   = (state == tgc_pkg::S_OUT);
  assign out_ch.gesture = gesture;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_pressed       <= 1'b0;
      hold_sent        <= 1'b0;
      tap_pending      <= 1'b0;
      press_start_time <= '0;
      tap_time         <= '0;
      start_x          <= '0;
      start_y          <= '0;
      last_x           <= '0;
      last_y           <= '0;
      tap_x            <= '0;
      tap_y            <= '0;
      path_length_q4   <= '0;
      job              <= tgc_pkg::J_STEP;
    end else begin
      case (state)
        tgc_pkg::S_IDLE: begin
          s_down  <= in_ch.touch_down;
          s_x     <= in_ch.pos_x;
          s_y     <= in_ch.pos_y;
          s_t     <= in_ch.time_ms;
          gesture <= tgc_pkg::G_NONE;
        end
        tgc_pkg::S_DECIDE: begin
          if (late_tap) begin
            tap_pending <= 1'b0;
            gesture     <= tgc_pkg::G_TAP;
          end else if (s_down && !is_pressed) begin
            is_pressed       <= 1'b1;
            hold_sent        <= 1'b0;
            press_start_time <= s_t;
            start_x          <= s_x;
            start_y          <= s_y;
            last_x           <= s_x;
            last_y           <= s_y;
            path_length_q4   <= '0;
          end else if (s_down) begin
            job   <= tgc_pkg::J_STEP;
            opa_x <= last_x;
            opa_y <= last_y;
            opb_x <= s_x;
            opb_y <= s_y;
          end else if (is_pressed && hold_sent) begin
            is_pressed  <= 1'b0;
            hold_sent   <= 1'b0;
            tap_pending <= 1'b0;
          end else if (is_pressed) begin
            job   <= tgc_pkg::J_DISP_UP;
            opa_x <= start_x;
            opa_y <= start_y;
            opb_x <= last_x;
            opb_y <= last_y;
          end
        end
        tgc_pkg::S_SQX: sq_acc <= SQ_BITS'(sq_prod);
        tgc_pkg::S_SQY: begin
          val  <= VAL_BITS'(sq_sum) << (2 * FRAC_BITS);
          rem  <= '0;
          root <= '0;
          cnt  <= CNT_BITS'(ROOT_BITS);
        end
        tgc_pkg::S_ROOT: begin
          // One result bit per cycle, two radicand bits brought down each time.
          val <= val << 2;
          cnt <= cnt - CNT_BITS'(1);
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[ROOT_BITS-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_BITS-2:0], 1'b0};
          end
        end
        tgc_pkg::S_POST: begin
          case (job)
            tgc_pkg::J_STEP: begin
              path_length_q4 <= (path_sum > 64'(PB'('1))) ? PB'('1) : path_sum[PB-1:0];
              last_x <= s_x;
              last_y <= s_y;
              job    <= tgc_pkg::J_DISP_DOWN;
              opa_x  <= start_x;
              opa_y  <= start_y;
              opb_x  <= s_x;
              opb_y  <= s_y;
            end
            tgc_pkg::J_DISP_DOWN: begin
              if (!hold_sent && dur >= TB'(hold_min_time) && root_w <= still_q &&
                  path_w * 64'd5 <= hold_path_lim) begin
                hold_sent   <= 1'b1;
                tap_pending <= 1'b0;
                gesture     <= tgc_pkg::G_HOLD;
              end
            end
            tgc_pkg::J_DISP_UP: begin
              is_pressed <= 1'b0;
              if (path_w >= stroke_q || root_w >= stroke_q) begin
                tap_pending <= 1'b0;
                gesture     <= tgc_pkg::G_STROKE;
              end else if (dur <= TB'(tap_max_time) && root_w <= still_q) begin
                if (tap_pending) begin
                  job   <= tgc_pkg::J_TAP_DIST;
                  opa_x <= start_x;
                  opa_y <= start_y;
                  opb_x <= tap_x;
                  opb_y <= tap_y;
                end else begin
                  tap_pending <= 1'b1;
                  tap_time    <= s_t;
                  tap_x       <= start_x;
                  tap_y       <= start_y;
                end
              end
            end
            default: begin
              if (late_gap <= TB'(double_tap_window) && root_w <= reach_q) begin
                tap_pending <= 1'b0;
                gesture     <= tgc_pkg::G_DOUBLE;
              end else begin
                tap_pending <= 1'b1;
                tap_time    <= s_t;
                tap_x       <= start_x;
                tap_y       <= start_y;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/tgc_checker.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier checker
// Port-level checks on the item flow of the classifier.
// ----------------------------------------------------------------------------
module tgc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tgc_pkg::GEST_BITS-1:0] gesture
);

  // A waiting result holds its code until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gesture))
    else $error("gesture changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gesture <= tgc_pkg::G_STROKE)
    else $error("gesture code out of range");

  // Only one item is in the block at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("ready for input while a result waits");

  a_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated");

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .gesture   (out_ch.gesture)
);

>>> test/tb_touch_gesture_classifier_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch gesture classifier testbench
// Drives touch samples through the classifier under several register
// settings and idling patterns. Each gesture is checked against a predictor
// kept inside the testbench or against the code given in the table. A short table
// of hand-picked samples comes first, then random taps, holds, strokes and noise.
// ----------------------------------------------------------------------------
module tb_touch_gesture_classifier_unit;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = 60;

  typedef struct {
    logic              down;
    logic [11:0]       x;
    logic [11:0]       y;
    logic [31:0]       t;
    logic              known;
    tgc_pkg::gesture_t g;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [tgc_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [tgc_pkg::CFG_DATA_BITS-1:0] cfg_data;

  tgc_in_if  in_ch ();
  tgc_out_if out_ch ();

  touch_gesture_classifier_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers and gesture state.
  logic [15:0] tap_max, dbl_window, hold_min;
  logic [9:0]  still_px, stroke_px, reach_px;
  logic        pressed, hold_done, tap_waiting;
  logic [31:0] press_t, tap_t;
  logic [11:0] sx, sy, lx, ly, tx, ty;
  logic [23:0] path_q;

  tgc_pkg::gesture_t gesture_q[$];
  int       errors = 0;
  int       cycles = 0;
  int       send_idle = 0;
  int       recv_stall = 0;
  logic [31:0] now_ms = 32'd5000;

  function automatic logic [31:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] span_q4(logic [11:0] ax, logic [11:0] ay,
                                         logic [11:0] bx, logic [11:0] by);
    logic [63:0] dx, dy;
    dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
    dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
    return root_floor((dx * dx + dy * dy) << 8);
  endfunction

  function automatic void defaults_load();
    tap_max = 16'd250; dbl_window = 16'd300; hold_min = 16'd600;
    still_px = 10'd10; stroke_px = 10'd24; reach_px = 10'd24;
    pressed = 1'b0; hold_done = 1'b0; tap_waiting = 1'b0;
    press_t = '0; tap_t = '0;
    sx = '0; sy = '0; lx = '0; ly = '0; tx = '0; ty = '0; path_q = '0;
  endfunction

  function automatic void register_store(logic [2:0] idx, logic [15:0] d);
    case (idx)
      tgc_pkg::R_TAP_MAX:
        tap_max = (d < tgc_pkg::TAP_MAX_MIN) ? tgc_pkg::TAP_MAX_MIN : d;
      tgc_pkg::R_DBL_WINDOW:
        dbl_window = (d < tgc_pkg::DBL_WINDOW_MIN) ? tgc_pkg::DBL_WINDOW_MIN : d;
      tgc_pkg::R_HOLD_MIN:
        hold_min = (d < tgc_pkg::HOLD_MIN_MIN) ? tgc_pkg::HOLD_MIN_MIN : d;
      tgc_pkg::R_STILL:
        still_px = (d[9:0] < tgc_pkg::STILL_MIN) ? tgc_pkg::STILL_MIN : d[9:0];
      tgc_pkg::R_STROKE: stroke_px = d[9:0];
      tgc_pkg::R_REACH:  reach_px  = d[9:0];
      default: ;
    endcase
  endfunction

  function automatic tgc_pkg::gesture_t classify(logic down, logic [11:0] x,
                                                 logic [11:0] y, logic [31:0] t);
    logic [63:0] still_q, stroke_q, reach_q, p;
    logic [31:0] dur, disp, gap, td;
    tgc_pkg::gesture_t g;
    g = tgc_pkg::G_NONE;
    still_q  = 64'(still_px) << 4;
    stroke_q = (stroke_px > still_px + 8) ? 64'(stroke_px) << 4
                                          : (64'(still_px) + 64'd8) << 4;
    reach_q  = (reach_px > still_px) ? 64'(reach_px) << 4 : still_q;
    if (tap_waiting && !down && (t - tap_t) > 32'(dbl_window)) begin
      tap_waiting = 1'b0;
      g = tgc_pkg::G_TAP;
    end else if (down) begin
      if (!pressed) begin
        pressed = 1'b1; hold_done = 1'b0; press_t = t;
        sx = x; lx = x; sy = y; ly = y; path_q = '0;
      end else begin
        p = 64'(path_q) + 64'(span_q4(lx, ly, x, y));
        path_q = (p > 64'hFFFFFF) ? 24'hFFFFFF : p[23:0];
        lx = x; ly = y;
        dur = t - press_t;
        disp = span_q4(sx, sy, x, y);
        if (!hold_done && dur >= 32'(hold_min) && 64'(disp) <= still_q &&
            64'(path_q) * 64'd5 <= still_q * 64'd9) begin
          hold_done = 1'b1; tap_waiting = 1'b0; g = tgc_pkg::G_HOLD;
        end
      end
    end else if (pressed) begin
      dur = t - press_t;
      disp = span_q4(sx, sy, lx, ly);
      pressed = 1'b0;
      if (hold_done) begin
        hold_done = 1'b0; tap_waiting = 1'b0;
      end else if (64'(path_q) >= stroke_q || 64'(disp) >= stroke_q) begin
        tap_waiting = 1'b0; g = tgc_pkg::G_STROKE;
      end else if (dur <= 32'(tap_max) && 64'(disp) <= still_q) begin
        gap = t - tap_t;
        td = span_q4(sx, sy, tx, ty);
        if (tap_waiting && gap <= 32'(dbl_window) && 64'(td) <= reach_q) begin
          tap_waiting = 1'b0; g = tgc_pkg::G_DOUBLE;
        end else begin
          tap_waiting = 1'b1; tap_t = t; tx = sx; ty = sy;
        end
      end
    end
    return g;
  endfunction

  // Presents one item, waits for its acceptance and records what is owed.
  task automatic send(logic down, logic [11:0] x, logic [11:0] y, logic [31:0] t,
                      logic known, tgc_pkg::gesture_t g);
    tgc_pkg::gesture_t p;
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid      <= 1'b1;
    in_ch.touch_down <= down;
    in_ch.pos_x      <= x;
    in_ch.pos_y      <= y;
    in_ch.time_ms    <= t;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    p = classify(down, x, y, t);
    gesture_q.push_back(known ? g : p);
  endtask

  task automatic go(logic down, logic [11:0] x, logic [11:0] y, int dt);
    now_ms = now_ms + 32'(dt);
    send(down, x, y, now_ms, 1'b0, tgc_pkg::G_NONE);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (gesture_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [15:0] d);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    register_store(idx, d);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [11:0] nudge(logic [11:0] c, int r);
    int v;
    v = int'(c) + int'($urandom_range(2 * r)) - r;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic gesture_burst();
    int kind, n;
    logic [11:0] bx, by;
    kind = $urandom_range(9);
    bx = 12'($urandom_range(4095));
    by = 12'($urandom_range(4095));
    n = $urandom_range(4);
    case (kind)
      0, 1, 2: begin
        // Quick press with jitter, sometimes followed by a second one nearby.
        go(1'b1, bx, by, $urandom_range(600));
        repeat (n) go(1'b1, nudge(bx, 3), nudge(by, 3), $urandom_range(40));
        go(1'b0, 12'($urandom), 12'($urandom), $urandom_range(20, 200));
        if ($urandom_range(1)) begin
          go(1'b1, nudge(bx, 30), nudge(by, 30), $urandom_range(20, 300));
          go(1'b0, 12'($urandom), 12'($urandom), $urandom_range(20, 300));
        end
      end
      3, 4: begin
        go(1'b1, bx, by, $urandom_range(800));
        repeat (n + 2) go(1'b1, nudge(bx, 6), nudge(by, 6), $urandom_range(100, 400));
        go(1'b0, bx, by, $urandom_range(200));
      end
      5, 6: begin
        go(1'b1, bx, by, $urandom_range(800));
        repeat (n + 1) begin
          bx = nudge(bx, 40); by = nudge(by, 40);
          go(1'b1, bx, by, $urandom_range(50));
        end
        go(1'b0, bx, by, $urandom_range(300));
      end
      7: go(1'b0, 12'($urandom), 12'($urandom), $urandom_range(200, 1200));
      default: begin
        now_ms = $urandom;
        send(1'($urandom_range(1)), 12'($urandom), 12'($urandom), now_ms, 1'b0,
             tgc_pkg::G_NONE);
      end
    endcase
  endtask

  sample_row_t script[] = '{
    '{1'b0, 12'd0,    12'd0,    32'd0,         1'b1, tgc_pkg::G_NONE},
    '{1'b1, 12'd100,  12'd100,  32'd1000,      1'b1, tgc_pkg::G_NONE},
    '{1'b0, 12'd100,  12'd100,  32'd1100,      1'b1, tgc_pkg::G_NONE},
    '{1'b1, 12'd102,  12'd100,  32'd1200,      1'b1, tgc_pkg::G_NONE},
    '{1'b0, 12'd102,  12'd100,  32'd1250,      1'b1, tgc_pkg::G_DOUBLE},
    '{1'b1, 12'd4095, 12'd4095, 32'd2000,      1'b1, tgc_pkg::G_NONE},
    '{1'b1, 12'd4095, 12'd4095, 32'd2700,      1'b1, tgc_pkg::G_HOLD},
    '{1'b1, 12'd4095, 12'd4095, 32'd2800,      1'b1, tgc_pkg::G_NONE},
    '{1'b0, 12'd0,    12'd0,    32'd2900,      1'b1, tgc_pkg::G_NONE},
    '{1'b1, 12'd0,    12'd0,    32'd3000,      1'b1, tgc_pkg::G_NONE},
    '{1'b1, 12'd4095, 12'd0,    32'd3010,      1'b1, tgc_pkg::G_NONE},
    '{1'b0, 12'd4095, 12'd4095, 32'd3020,      1'b1, tgc_pkg::G_STROKE},
    '{1'b1, 12'd500,  12'd500,  32'd4000,      1'b1, tgc_pkg::G_NONE},
    '{1'b0, 12'd500,  12'd500,  32'd4100,      1'b1, tgc_pkg::G_NONE},
    '{1'b0, 12'd500,  12'd500,  32'd4500,      1'b1, tgc_pkg::G_TAP},
    '{1'b1, 12'd10,   12'd10,   32'hFFFF_FFF0, 1'b1, tgc_pkg::G_NONE},
    '{1'b0, 12'd10,   12'd10,   32'h0000_0050, 1'b1, tgc_pkg::G_NONE},
    '{1'b0, 12'd10,   12'd10,   32'h0000_017D, 1'b1, tgc_pkg::G_TAP},
    '{1'b1, 12'd0,    12'd4095, 32'hFFFF_FFFF, 1'b1, tgc_pkg::G_NONE},
    '{1'b1, 12'd5,    12'd4090, 32'h0000_0100, 1'b0, tgc_pkg::G_NONE},
    '{1'b1, 12'd2730, 12'd1365, 32'h0000_0400, 1'b0, tgc_pkg::G_NONE},
    '{1'b0, 12'd1365, 12'd2730, 32'h0000_0500, 1'b0, tgc_pkg::G_NONE}
  };

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_touch_gesture_classifier_unit: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (gesture_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected gesture %0d at cycle %0d", out_ch.gesture, cycles);
      end else begin
        if (out_ch.gesture !== gesture_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("gesture mismatch at cycle %0d: expected %0d, got %0d",
                     cycles, gesture_q[0], out_ch.gesture);
        end
        void'(gesture_q.pop_front());
      end
    end
  end

  initial begin
    int phase, k;
    rst <= 1'b1;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_ch.valid <= 1'b0; in_ch.touch_down <= 1'b0;
    in_ch.pos_x <= '0; in_ch.pos_y <= '0; in_ch.time_ms <= '0;
    defaults_load();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i])
      send(script[i].down, script[i].x, script[i].y, script[i].t,
           script[i].known, script[i].g);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 83; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 83; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      if (phase == 1) begin
        // Lowest settings: writes below the minimums are clamped.
        reg_write(tgc_pkg::R_TAP_MAX, 16'd0);
        reg_write(tgc_pkg::R_DBL_WINDOW, 16'd5);
        reg_write(tgc_pkg::R_HOLD_MIN, 16'd0);
        reg_write(tgc_pkg::R_STILL, 16'd0);
        reg_write(tgc_pkg::R_STROKE, 16'd0);
        reg_write(tgc_pkg::R_REACH, 16'd0);
        reg_write(3'd6, 16'hFFFF);
      end else if (phase == 3) begin
        reg_write(tgc_pkg::R_TAP_MAX, 16'hFFFF);
        reg_write(tgc_pkg::R_DBL_WINDOW, 16'hFFFF);
        reg_write(tgc_pkg::R_HOLD_MIN, 16'hFFFF);
        reg_write(tgc_pkg::R_STILL, 16'hFFFF);
        reg_write(tgc_pkg::R_STROKE, 16'h03FF);
        reg_write(tgc_pkg::R_REACH, 16'h03FF);
        reg_write(3'd7, 16'h0000);
      end else if (phase >= 4) begin
        reg_write(tgc_pkg::R_TAP_MAX, 16'($urandom_range(60, 400)));
        reg_write(tgc_pkg::R_DBL_WINDOW, 16'($urandom_range(100, 500)));
        reg_write(tgc_pkg::R_HOLD_MIN, 16'($urandom_range(380, 900)));
        reg_write(tgc_pkg::R_STILL, (phase == 7) ? 16'hFC00 | 16'($urandom_range(20))
                                                 : 16'($urandom_range(30)));
        reg_write(tgc_pkg::R_STROKE, 16'($urandom));
        reg_write(tgc_pkg::R_REACH, 16'($urandom_range(60)));
      end
      for (k = 0; k < 13; k++) gesture_burst();
      drain();
    end

    if (errors == 0) begin
      $display("tb_touch_gesture_classifier_unit: done, clean");
    end else begin
      $display("tb_touch_gesture_classifier_unit: done, errors");
    end
    $finish;
  end

endmodule
